@@ rtl/core/xxh64_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_pkg
// Shared constants, types and helpers for the xxHash64 stream core.
// ----------------------------------------------------------------------------
package xxh64_pkg;

  localparam logic [63:0] Prime1 = 64'd11400714785074694791;
  localparam logic [63:0] Prime2 = 64'd14029467366897019727;
  localparam logic [63:0] Prime3 = 64'd1609587929392839161;
  localparam logic [63:0] Prime4 = 64'd9650029242287828579;
  localparam logic [63:0] Prime5 = 64'd2870177450012600261;
  localparam int unsigned FifoDepthDefault = 2;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        fin;
  } xxh64_item_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/xxhash64_stream_hash_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxhash64_stream_hash_core
// Seed-zero xxHash64 over a stream of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Items enter a small queue and are consumed by a hash engine built around
// one 32x32 multiplier, which forms each 64-bit product in passes. A word
// that does not complete a stripe is stored; the word that completes a
// 32-byte stripe drives two products per lane over the four lanes. The last
// item then goes through a decision step, the merge when 32 or more bytes
// were sent, the length add, a round per buffered tail word, a 4-byte step,
// a step per trailing byte, and the final mix and result write. A last item
// waits while an earlier hash has not been popped.
module xxhash64_stream_hash_core #(
  parameter int unsigned FifoDepth = xxh64_pkg::FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      hash_value_o
);
  import xxh64_pkg::*;

  xxh64_item_t in_item, q_item;
  logic        q_avail, q_take;

  assign in_item.word = data_word_i;
  assign in_item.cnt  = byte_count_i;
  assign in_item.fin  = last_i;

  xxh64_front #(.Depth(FifoDepth)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .avail_o (q_avail),
    .item_o  (q_item),
    .take_i  (q_take)
  );

  xxh64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (q_avail),
    .item_i       (q_item),
    .take_o       (q_take),
    .empty_o      (empty),
    .hash_value_o (hash_value_o),
    .pop_i        (pop)
  );

endmodule
`default_nettype wire

@@ rtl/core/xxh64_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_front
// Input stage and item queue: takes items and holds them for the back end.
// ----------------------------------------------------------------------------
module xxh64_front #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire xxh64_pkg::xxh64_item_t   item_i,
  output logic                          full_o,
  output logic                          avail_o,
  output xxh64_pkg::xxh64_item_t        item_o,
  input  wire logic                     take_i
);
  import xxh64_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  xxh64_item_t mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;
  xxh64_item_t   in_c;

  always_comb begin
    in_c = item_i;
    if (!item_i.fin) begin
      in_c.cnt = 4'd8;
    end else if (item_i.cnt > 4'd8) begin
      in_c.cnt = 4'd8;
    end
  end

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign avail_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && avail_o;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= in_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/xxh64_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh64_back
// Hash engine: lane rounds, merge, tail and avalanche on one shared
// 32x32 multiplier (lo*lo, lo*hi and hi*lo passes per 64-bit product),
// with a one-entry result register.
// ----------------------------------------------------------------------------
module xxh64_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   avail_i,
  input  wire xxh64_pkg::xxh64_item_t item_i,
  output logic                        take_o,
  output logic                        empty_o,
  output logic [63:0]                 hash_value_o,
  input  wire logic                   pop_i
);
  import xxh64_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000_0000_0000_0001,
    S_LMUL   = 16'b0000_0000_0000_0010,
    S_LFIN   = 16'b0000_0000_0000_0100,
    S_FIN    = 16'b0000_0000_0000_1000,
    S_MRG1   = 16'b0000_0000_0001_0000,
    S_MRG2   = 16'b0000_0000_0010_0000,
    S_MRG3   = 16'b0000_0000_0100_0000,
    S_ADDL   = 16'b0000_0000_1000_0000,
    S_T8A    = 16'b0000_0001_0000_0000,
    S_T8B    = 16'b0000_0010_0000_0000,
    S_T8C    = 16'b0000_0100_0000_0000,
    S_T4     = 16'b0000_1000_0000_0000,
    S_T1     = 16'b0001_0000_0000_0000,
    S_AV     = 16'b0010_0000_0000_0000,
    S_OUT    = 16'b0100_0000_0000_0000,
    S_T1B    = 16'b1000_0000_0000_0000
  } state_e;

  state_e      st_q, st_d;
  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic [63:0] sw_q [3];
  logic [1:0]  wis_q, wis_d;
  logic [63:0] len_q, len_d;
  logic [63:0] h_q, h_d;
  logic [63:0] t_q, t_d;
  logic [63:0] w_q, w_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [2:0]  sub_q, sub_d;
  logic [1:0]  idx_q, idx_d;
  logic        res_v_q, res_v_d;
  logic [63:0] res_q, res_d;
  logic        sw_we;
  logic [1:0]  sw_wa;
  logic [63:0] sw_wd;
  logic [63:0] ma, mb, mp;
  logic [1:0]  mph_q, mph_d;
  logic [63:0] macc_q, macc_d;
  logic [31:0] mx, my;
  logic [63:0] mxy;
  logic        mul_en;

  assign empty_o = !res_v_q;
  assign hash_value_o = res_q;

  // low 64 bits of ma*mb: lo*lo, then lo*hi and hi*lo cross terms
  always_comb begin
    case (mph_q)
      2'd0: begin
        mx = ma[31:0];
        my = mb[31:0];
      end
      2'd1: begin
        mx = ma[31:0];
        my = mb[63:32];
      end
      default: begin
        mx = ma[63:32];
        my = mb[31:0];
      end
    endcase
  end

  assign mxy = {32'd0, mx} * {32'd0, my};

  always_comb begin
    mp = macc_q + {mxy[31:0], 32'd0};
    if (mph_q == 2'd0) begin
      macc_d = mxy;
    end else begin
      macc_d = mp;
    end
  end

  always_comb begin
    st_d = st_q; wis_d = wis_q; len_d = len_q; h_d = h_q; t_d = t_q; w_d = w_q;
    cnt_d = cnt_q; sub_d = sub_q; idx_d = idx_q;
    res_v_d = res_v_q && !pop_i; res_d = res_q;
    for (int i = 0; i < 4; i++) lane_d[i] = lane_q[i];
    sw_we = 1'b0; sw_wa = wis_q; sw_wd = item_i.word;
    take_o = 1'b0; ma = '0; mb = '0;
    case (st_q)
      S_IDLE: begin
        if (avail_i && !(item_i.fin && res_v_q && !pop_i)) begin
          take_o = 1'b1;
          len_d = len_q + 64'(item_i.cnt);
          w_d = item_i.word;
          cnt_d = (item_i.cnt == 4'd8) ? 4'd0 : item_i.cnt;
          if (item_i.cnt == 4'd8) begin
            if (wis_q == 2'd3) begin
              idx_d = 2'd0;
              st_d = S_LMUL;
            end else begin
              sw_we = 1'b1;
              wis_d = wis_q + 2'd1;
              st_d = item_i.fin ? S_FIN : S_IDLE;
            end
          end else begin
            st_d = S_FIN;
          end
          sub_d = {2'b00, item_i.fin};
        end
      end
      S_LMUL: begin
        ma = (idx_q == 2'd3) ? w_q : sw_q[idx_q];
        mb = Prime2;
        t_d = rotl64(lane_q[idx_q] + mp, 31);
        st_d = S_LFIN;
      end
      S_LFIN: begin
        ma = t_q; mb = Prime1;
        lane_d[idx_q] = mp;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          wis_d = 2'd0;
          st_d = sub_q[0] ? S_FIN : S_IDLE;
        end else begin
          st_d = S_LMUL;
        end
      end
      S_FIN: begin
        idx_d = 2'd0;
        if (len_q >= 64'd32) begin
          h_d = rotl64(lane_q[0], 1) + rotl64(lane_q[1], 7) +
                rotl64(lane_q[2], 12) + rotl64(lane_q[3], 18);
          st_d = S_MRG1;
        end else begin
          h_d = Prime5;
          st_d = S_ADDL;
        end
      end
      S_MRG1: begin
        ma = lane_q[idx_q]; mb = Prime2;
        t_d = rotl64(mp, 31);
        st_d = S_MRG2;
      end
      S_MRG2: begin
        ma = t_q; mb = Prime1;
        h_d = h_q ^ mp;
        st_d = S_MRG3;
      end
      S_MRG3: begin
        ma = h_q; mb = Prime1;
        h_d = mp + Prime4;
        idx_d = idx_q + 2'd1;
        st_d = (idx_q == 2'd3) ? S_ADDL : S_MRG1;
      end
      S_ADDL: begin
        h_d = h_q + len_q;
        idx_d = 2'd0;
        st_d = S_T8A;
      end
      S_T8A: begin
        if (idx_q == wis_q || idx_q == 2'd3) begin
          st_d = (cnt_q >= 4'd4) ? S_T4 : S_T1;
          sub_d = 3'd0;
        end else begin
          ma = sw_q[idx_q]; mb = Prime2;
          t_d = rotl64(mp, 31);
          st_d = S_T8B;
        end
      end
      S_T8B: begin
        ma = t_q; mb = Prime1;
        h_d = rotl64(h_q ^ mp, 27);
        st_d = S_T8C;
      end
      S_T8C: begin
        ma = h_q; mb = Prime1;
        h_d = mp + Prime4;
        idx_d = idx_q + 2'd1;
        st_d = S_T8A;
      end
      S_T4: begin
        if (sub_q == 3'd0) begin
          ma = {32'd0, w_q[31:0]}; mb = Prime1;
          h_d = rotl64(h_q ^ mp, 23);
          sub_d = 3'd1;
        end else begin
          ma = h_q; mb = Prime2;
          h_d = mp + Prime3;
          w_d = w_q;
          cnt_d = cnt_q;
          sub_d = 3'd0;
          idx_d = 2'd0;
          st_d = S_T1;
          t_d = 64'd4;
        end
      end
      S_T1: begin
        if (t_q[3:0] >= cnt_q) begin
          sub_d = 3'd0;
          st_d = S_AV;
        end else begin
          ma = {56'd0, 8'(w_q >> {t_q[2:0], 3'b000})}; mb = Prime5;
          h_d = rotl64(h_q ^ mp, 11);
          st_d = S_T1B;
        end
      end
      S_T1B: begin
        ma = h_q; mb = Prime1;
        h_d = mp;
        t_d = t_q + 64'd1;
        st_d = S_T1;
      end
      S_AV: begin
        sub_d = sub_q + 3'd1;
        case (sub_q)
          3'd0: begin
            ma = h_q ^ (h_q >> 33); mb = Prime2;
            h_d = mp;
          end
          3'd1: begin
            ma = h_q ^ (h_q >> 29); mb = Prime3;
            h_d = mp;
          end
          default: begin
            h_d = h_q ^ (h_q >> 32);
            st_d = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (!res_v_d) begin
          res_v_d = 1'b1;
          res_d = h_q;
          lane_d[0] = Prime1 + Prime2;
          lane_d[1] = Prime2;
          lane_d[2] = 64'd0;
          lane_d[3] = 64'd0 - Prime1;
          wis_d = 2'd0;
          len_d = 64'd0;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    if (st_q == S_T8A && (idx_q == wis_q || idx_q == 2'd3)) begin
      t_d = 64'd0;
      if (cnt_q >= 4'd4) st_d = S_T4;
    end
    // every product uses a nonzero constant operand; hold until pass three
    mul_en = (mb != '0);
    mph_d = (mul_en && mph_q != 2'd2) ? mph_q + 2'd1 : 2'd0;
    if (mul_en && mph_q != 2'd2) begin
      st_d = st_q; h_d = h_q; t_d = t_q; w_d = w_q;
      cnt_d = cnt_q; sub_d = sub_q; idx_d = idx_q;
      wis_d = wis_q; len_d = len_q;
      for (int i = 0; i < 4; i++) lane_d[i] = lane_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_we) begin
      sw_q[sw_wa] <= sw_wd;
    end
    h_q    <= h_d;
    t_q    <= t_d;
    w_q    <= w_d;
    res_q  <= res_d;
    macc_q <= macc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      lane_q[0] <= Prime1 + Prime2;
      lane_q[1] <= Prime2;
      lane_q[2] <= 64'd0;
      lane_q[3] <= 64'd0 - Prime1;
      wis_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sub_q   <= '0;
      idx_q   <= '0;
      res_v_q <= 1'b0;
      mph_q   <= '0;
    end else begin
      st_q    <= st_d;
      for (int i = 0; i < 4; i++) lane_q[i] <= lane_d[i];
      wis_q   <= wis_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sub_q   <= sub_d;
      idx_q   <= idx_d;
      res_v_q <= res_v_d;
      mph_q   <= mph_d;
    end
  end

endmodule
`default_nettype wire

@@ tb/xxh64_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_checker
// Watches the input and result queues of the xxHash64 core, computes the
// expected hash of every message and compares it with each popped result.
// ----------------------------------------------------------------------------
module xxh64_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [63:0] hash_value_i,
  output int          fail_count_o,
  output int          pending_o
);
  import xxh64_pkg::*;

  logic [63:0] lanes [4];
  logic [63:0] stripe [3];
  int unsigned stripe_fill;
  logic [63:0] msg_len;
  logic [63:0] hash_queue [$];

  function automatic logic [63:0] rot(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] mix_round(input logic [63:0] acc, input logic [63:0] w);
    return rot(acc + w * Prime2, 31) * Prime1;
  endfunction

  task automatic clear_msg();
    lanes[0] = Prime1 + Prime2;
    lanes[1] = Prime2;
    lanes[2] = 64'd0;
    lanes[3] = 64'd0 - Prime1;
    stripe_fill = 0;
    msg_len = 64'd0;
  endtask

  task automatic add_word(input logic [63:0] w);
    if (stripe_fill == 3) begin
      lanes[0] = mix_round(lanes[0], stripe[0]);
      lanes[1] = mix_round(lanes[1], stripe[1]);
      lanes[2] = mix_round(lanes[2], stripe[2]);
      lanes[3] = mix_round(lanes[3], w);
      stripe_fill = 0;
    end else begin
      stripe[stripe_fill] = w;
      stripe_fill++;
    end
  endtask

  task automatic absorb(input logic [63:0] w, input logic [3:0] cnt_in, input logic fin);
    logic [63:0] h;
    int unsigned cnt;
    int unsigned i;
    if (!fin) begin
      msg_len += 64'd8;
      add_word(w);
      return;
    end
    cnt = (cnt_in > 8) ? 8 : cnt_in;
    msg_len += 64'(cnt);
    if (cnt == 8) begin
      add_word(w);
      cnt = 0;
    end
    if (msg_len >= 64'd32) begin
      h = rot(lanes[0], 1) + rot(lanes[1], 7) + rot(lanes[2], 12) + rot(lanes[3], 18);
      for (i = 0; i < 4; i++) h = (h ^ mix_round(64'd0, lanes[i])) * Prime1 + Prime4;
    end else begin
      h = Prime5;
    end
    h += msg_len;
    for (i = 0; i < stripe_fill; i++)
      h = rot(h ^ mix_round(64'd0, stripe[i]), 27) * Prime1 + Prime4;
    i = 0;
    if (cnt >= 4) begin
      h ^= {32'd0, w[31:0]} * Prime1;
      h = rot(h, 23) * Prime2 + Prime3;
      i = 4;
    end
    for (; i < cnt; i++) begin
      h ^= {56'd0, w[8*i +: 8]} * Prime5;
      h = rot(h, 11) * Prime1;
    end
    h ^= h >> 33;
    h *= Prime2;
    h ^= h >> 29;
    h *= Prime3;
    h ^= h >> 32;
    hash_queue.push_back(h);
    clear_msg();
  endtask

  initial begin
    fail_count_o = 0;
    clear_msg();
  end

  assign pending_o = hash_queue.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_i) begin
        if (hash_queue.size() == 0) begin
          $display("%0t: unexpected hash %h", $time, hash_value_i);
          fail_count_o++;
        end else begin
          if (hash_queue[0] !== hash_value_i) begin
            $display("%0t: hash_value expected %h actual %h", $time, hash_queue[0],
                     hash_value_i);
            fail_count_o++;
          end
          void'(hash_queue.pop_front());
        end
      end
      if (push_i && !full_i) absorb(data_word_i, byte_count_i, last_i);
    end
  end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the xxHash64 stream core: directed messages, then random
// messages of mixed length under four idle/stall phases; verdict at the end.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] data_word = 64'd0;
  logic [3:0]  byte_count = 4'd0;
  logic        last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] hash_value;
  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  int          items_sent = 0;

  always #5 clk_i = ~clk_i;

  xxhash64_stream_hash_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .data_word_i(data_word), .byte_count_i(byte_count), .last_i(last),
    .empty(empty), .pop(pop), .hash_value_o(hash_value)
  );

  xxh64_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .full_i(full),
    .data_word_i(data_word), .byte_count_i(byte_count), .last_i(last),
    .empty_i(empty), .pop_i(pop), .hash_value_i(hash_value),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) pop <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one transfer; holds push until accepted, leaves it to the next caller
  task automatic send_item(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    data_word <= w;
    byte_count <= cnt;
    last <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_msg(input int words, input logic [63:0] w_last, input logic [3:0] cnt);
    for (int k = 0; k < words; k++) send_item(rand64(), 4'($urandom_range(15)), 1'b0);
    send_item(w_last, cnt, 1'b1);
  endtask

  task automatic random_msg();
    int words;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) words = $urandom_range(4);
    else if (pick < 90) words = $urandom_range(12);
    else words = $urandom_range(40);
    send_msg(words, rand64(), 4'($urandom_range(pick < 5 ? 15 : 8)));
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int c = 0; c <= 15; c++) send_msg(0, rand64(), 4'(c));
    send_msg(0, 64'd0, 4'd8);
    send_msg(0, '1, 4'd8);
    send_msg(3, '1, 4'd0);
    send_msg(3, 64'd0, 4'd8);
    send_msg(4, '1, 4'd5);
    // let everything drain before the random part
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 7 : 51) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 7 : 51) : 0;
      while (items_sent < 40 + 380 * (phase + 1)) random_msg();
    end
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/xxh64_pkg.sv
rtl/core/xxh64_front.sv
rtl/core/xxh64_back.sv
rtl/core/xxhash64_stream_hash_core.sv
tb/xxh64_checker.sv
tb/tb_top.sv
